/* rtl/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg: shared types for the subrange integer sorter
// Control state, the broadcast control word for the cell row, field widths.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // field widths fixed by the item format
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MARK,
    ST_SORT,
    ST_EMIT
  } state_t;

  // control word broadcast to every cell
  typedef struct packed {
    logic             shift;    // move contents one cell towards cell 0
    logic             mark;     // latch the in-range flag
    logic             sort_en;  // compare-exchange round active
    logic             parity;   // which pairs exchange this round
    logic [POS_W-1:0] lo;       // first sorted position
    logic [POS_W-1:0] hi;       // last sorted position, already clamped
  } ctrl_t;

endpackage

/* rtl/subrange_integer_sorter.sv */
// ----------------------------------------------------------------------------
// subrange_integer_sorter: sorts a position range of a list of integers
// Row of compare-exchange cells with a small load/sort/emit sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_* one per cycle: tdata holds the element and,
//   on the first item of a list, the inclusive range to sort; tlast ends
//   the list. Elements beyond MAX_ELEMENTS are dropped, but a dropped item
//   with tlast still ends the list.
//   After the last item the block marks which cells lie in the range, then
//   runs odd-even transposition rounds across the cell row. It then shifts
//   the row towards cell 0, which drives m_*; idle shifts bring the first
//   element there, then one element leaves per cycle while m_tready is
//   high. m_tlast marks the final element.
//   s_tready is high only while loading. When the receiver stalls the row
//   holds still and m_tdata stays put.
//   Reset empties the row and returns to loading; no clearing pass needed.
// ----------------------------------------------------------------------------
module subrange_integer_sorter #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // element_value[31:0], range_low[37:32],
                                 // range_high[43:38], zeros[47:44]
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sorted_value[31:0]
  output logic        m_tlast    // is_final
);

  localparam int N  = MAX_ELEMENTS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int PW = ssi_pkg::POS_W;
  localparam int VW = ssi_pkg::VALUE_W;

  ssi_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   round, round_next;
  logic [PW-1:0]   sort_low, sort_high;
  ssi_pkg::ctrl_t  ctrl;

  logic signed [VW-1:0] cell_value [N];
  logic                 cell_valid [N];
  logic [IW-1:0]        cell_tag   [N];
  logic                 cell_flag  [N];

  logic signed [VW-1:0] feed_value;
  logic                 feed_valid;
  logic                 s_fire;
  logic                 m_fire;
  logic                 room;
  logic [CW-1:0]        last_pos;
  logic [PW-1:0]        hi_eff;

  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign room     = (count < CW'(N));
  assign last_pos = count - CW'(1);
  // last_pos fits the position width whenever the list holds an element
  assign hi_eff   = (sort_high > PW'(last_pos)) ? PW'(last_pos) : sort_high;

  // feed into the top cell: new element while loading, empties otherwise
  assign feed_value = s_tdata[VW-1:0];
  assign feed_valid = (state == ssi_pkg::ST_LOAD);

  // m_tvalid and m_tdata come straight from cell 0, m_tlast from cell 1, s_tready from the state
  assign s_tready = (state == ssi_pkg::ST_LOAD);
  assign m_tvalid = (state == ssi_pkg::ST_EMIT) && cell_valid[0];
  assign m_tdata  = cell_value[0];
  assign m_tlast  = !cell_valid[1];

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssi_pkg::ST_LOAD;
      count <= '0;
      round <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      round <= round_next;
    end
  end

  // range sampled on the first item of a list
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_low  <= '0;
      sort_high <= '0;
    end else if (s_fire && (count == '0)) begin
      sort_low  <= s_tdata[VW+PW-1:VW];
      sort_high <= s_tdata[VW+2*PW-1:VW+PW];
    end
  end

  // next state and cell control
  always_comb begin
    state_next   = state;
    count_next   = count;
    round_next   = round;
    ctrl.shift   = 1'b0;
    ctrl.mark    = 1'b0;
    ctrl.sort_en = 1'b0;
    ctrl.parity  = round[0];
    ctrl.lo      = sort_low;
    ctrl.hi      = hi_eff;
    unique case (state)
      ssi_pkg::ST_LOAD: begin
        if (s_fire) begin
          if (room) begin
            ctrl.shift = 1'b1;
            count_next = count + CW'(1);
          end
          if (s_tlast) begin
            state_next = ssi_pkg::ST_MARK;
          end
        end
      end
      ssi_pkg::ST_MARK: begin
        ctrl.mark  = 1'b1;
        round_next = '0;
        state_next = ssi_pkg::ST_SORT;
      end
      ssi_pkg::ST_SORT: begin
        ctrl.sort_en = 1'b1;
        round_next   = round + CW'(1);
        if (round == CW'(N - 1)) begin
          state_next = ssi_pkg::ST_EMIT;
        end
      end
      ssi_pkg::ST_EMIT: begin
        // idle shifts until the first element reaches cell 0, then shift whenever m_tready is high
        ctrl.shift = !cell_valid[0] || m_tready;
        if (m_fire && m_tlast) begin
          count_next = '0;
          state_next = ssi_pkg::ST_LOAD;
        end
      end
      default: state_next = ssi_pkg::ST_LOAD;
    endcase
  end

  // the cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [VW-1:0] r_value;
    logic                 r_valid;
    logic [IW-1:0]        r_tag;
    logic                 r_flag;
    logic signed [VW-1:0] l_value;
    logic                 l_flag;

    if (i == N - 1) begin : g_top
      assign r_value = feed_value;
      assign r_valid = feed_valid;
      assign r_tag   = count[IW-1:0];
      assign r_flag  = 1'b0;
    end else begin : g_mid
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
      assign r_tag   = cell_tag[i+1];
      assign r_flag  = cell_flag[i+1];
    end

    if (i == 0) begin : g_bot
      assign l_value = '0;
      assign l_flag  = 1'b0;
    end else begin : g_up
      assign l_value = cell_value[i-1];
      assign l_flag  = cell_flag[i-1];
    end

    ssi_cell #(
      .IW  (IW),
      .ODD (i % 2 == 1)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .right_value (r_value),
      .right_valid (r_valid),
      .right_tag   (r_tag),
      .right_flag  (r_flag),
      .left_value  (l_value),
      .left_flag   (l_flag),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .tag         (cell_tag[i]),
      .flag        (cell_flag[i])
    );
  end

endmodule

/* rtl/ssi_cell.sv */
// ----------------------------------------------------------------------------
// ssi_cell: one slot of the sorting row
// Holds one element with its list position; shifts, marks and does
// odd-even compare-exchange with its neighbours.
// ----------------------------------------------------------------------------
module ssi_cell #(
  parameter int IW  = 6,
  parameter bit ODD = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ssi_pkg::ctrl_t                     ctrl,
  // right neighbour (next higher cell, or the row's feed)
  input  logic signed [ssi_pkg::VALUE_W-1:0] right_value,
  input  logic                               right_valid,
  input  logic [IW-1:0]                      right_tag,
  input  logic                               right_flag,
  // left neighbour (next lower cell)
  input  logic signed [ssi_pkg::VALUE_W-1:0] left_value,
  input  logic                               left_flag,
  output logic signed [ssi_pkg::VALUE_W-1:0] value,
  output logic                               valid,
  output logic [IW-1:0]                      tag,
  output logic                               flag
);

  logic is_low;
  logic take_right;
  logic take_left;
  logic in_range;

  // this cell is the lower member of its pair when parities agree
  assign is_low     = (ODD == ctrl.parity);
  assign take_right = is_low && flag && right_flag && (value > right_value);
  assign take_left  = !is_low && flag && left_flag && (left_value > value);
  assign in_range   = valid && (ssi_pkg::POS_W'(tag) >= ctrl.lo) &&
                      (ssi_pkg::POS_W'(tag) <= ctrl.hi);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end
  end

  // payload: shift, mark, exchange
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
      tag   <= right_tag;
    end else if (ctrl.sort_en) begin
      if (take_right) begin
        value <= right_value;
      end else if (take_left) begin
        value <= left_value;
      end
    end
    if (ctrl.mark) begin
      flag <= in_range;
    end
  end

endmodule

/* rtl/ssi_checker.sv */
// ----------------------------------------------------------------------------
// ssi_checker: port-level checks for the subrange integer sorter
// Watches both channels and the phase ordering between them.
// ----------------------------------------------------------------------------
module ssi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // loading and emitting never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is offered");

  // end of a list closes the input channel
  a_load_close: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still ready after the last item");

  // final result ends the output run
  a_emit_close: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("output not closed after the final item");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind subrange_integer_sorter ssi_checker u_ssi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* sim/tb_subrange_integer_sorter.sv */
// ----------------------------------------------------------------------------
// tb_subrange_integer_sorter: self-checking bench for the subrange sorter
// Streams lists of signed integers with their sort ranges into the block,
// predicts the partly sorted lists in a scoreboard and checks every item
// that leaves the block, with and without random idling on both sides.
// ----------------------------------------------------------------------------
module tb_subrange_integer_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = ssi_pkg::VALUE_W;
  localparam int PW          = ssi_pkg::POS_W;
  localparam int MAX_ELEM    = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF    = 500;
  localparam int PHASE_ITEMS = 15;

  typedef enum int {
    VAL_FULL,
    VAL_NARROW,
    VAL_EXTREME
  } value_kind_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          last;
  } sorted_item_t;

  // predicts each list after the range sort and checks the output items
  class sort_scoreboard;
    logic [VW-1:0]  store [MAX_ELEM];
    int unsigned    count;
    logic [PW-1:0]  lo_q;
    logic [PW-1:0]  hi_q;
    sorted_item_t   due_q [$];
    int unsigned    errors;

    function new();
      count  = 0;
      lo_q   = '0;
      hi_q   = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_input(logic [VW-1:0] value, logic [PW-1:0] lo,
                             logic [PW-1:0] hi, logic last);
      int unsigned  top;
      int unsigned  k;
      int unsigned  m;
      logic [VW-1:0] v;
      sorted_item_t item;
      // range is taken from the first item of a list only
      if (count == 0) begin
        lo_q = lo;
        hi_q = hi;
      end
      // a full store drops the item but still honours its last flag
      if (count < MAX_ELEM) begin
        store[count] = value;
        count++;
      end
      if (!last) return;
      top = (hi_q > count - 1) ? count - 1 : hi_q;
      if (lo_q < top) begin
        for (k = lo_q + 1; k <= top; k++) begin
          v = store[k];
          m = k;
          while (m > lo_q && $signed(v) < $signed(store[m-1])) begin
            store[m] = store[m-1];
            m--;
          end
          store[m] = v;
        end
      end
      for (k = 0; k < count; k++) begin
        item.value = store[k];
        item.last  = (k + 1 == count);
        due_q = {due_q, item};
      end
      count = 0;
    endfunction

    function void check_result(logic [VW-1:0] value, logic last);
      sorted_item_t want;
      if (due_q.size() == 0) begin
        $error("unexpected item: sorted_value %h is_final %0b", value, last);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (value !== want.value) begin
        $error("sorted_value: expected %h, got %h", want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $error("is_final: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  sort_scoreboard sb;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_cycles  = 0;
  int idle_run     = 0;
  int items_sent   = 0;

  subrange_integer_sorter #(.MAX_ELEMENTS(MAX_ELEM)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial sb = new();

  // receiver: random stalls, plus a long hold-off when one is armed
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("subrange_integer_sorter: mismatch");
      $finish;
    end
  end

  function automatic logic [VW-1:0] pick_value(value_kind_t kind);
    logic [VW-1:0] v;
    case (kind)
      VAL_NARROW: v = 32'($urandom_range(0, 15)) - 32'd8;
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          3:       v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // offer one item, with a random gap first, and wait for acceptance
  task automatic send_item(input logic [VW-1:0] value, input logic [PW-1:0] lo,
                           input logic [PW-1:0] hi, input logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, hi, lo, value};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(value, lo, hi, last);
  endtask

  task automatic send_list(input int n, input logic [PW-1:0] lo,
                           input logic [PW-1:0] hi, input value_kind_t kind);
    logic [PW-1:0] lo_k;
    logic [PW-1:0] hi_k;
    for (int k = 0; k < n; k++) begin
      // only the first item's range counts, the rest carry noise
      lo_k = (k == 0) ? lo : PW'($urandom);
      hi_k = (k == 0) ? hi : PW'($urandom);
      send_item(pick_value(kind), lo_k, hi_k, k == n - 1);
    end
    items_sent += n;
  endtask

  task automatic send_random_list();
    int            n;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    if ($urandom_range(0, 3) != 0) begin
      lo = PW'($urandom_range(0, n - 1));
      hi = PW'($urandom_range(lo, n - 1));
    end else begin
      lo = PW'($urandom);
      hi = PW'($urandom);
    end
    send_list(n, lo, hi, value_kind_t'($urandom_range(0, 2)));
  endtask

  // stop offering, then wait for every predicted item to leave
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed lists, no idling
    send_list(1, 6'd0, 6'd63, VAL_EXTREME);   // single element
    send_list(2, 6'd0, 6'd1, VAL_EXTREME);    // minimal range
    send_list(5, 6'd1, 6'd3, VAL_FULL);       // inner range only
    send_list(4, 6'd3, 6'd1, VAL_FULL);       // reversed range
    send_list(3, 6'd2, 6'd2, VAL_FULL);       // single-position range
    send_list(4, 6'd6, 6'd63, VAL_FULL);      // low index past the list
    send_list(5, 6'd0, 6'd63, VAL_EXTREME);   // high index clamped
    drain();

    // random phases: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 67 : 0;
      rcv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 13 : 0;
      // long receiver hold-off so the block backs up into its input
      if (phase == 0) hold_cycles = HOLD_OFF;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) send_random_list();
      // full store, then overflow with the last item dropped
      if (phase == 1) send_list(MAX_ELEM, 6'($urandom), 6'd63, VAL_FULL);
      if (phase == 2) send_list(MAX_ELEM + 3, 6'd0, 6'd63, VAL_NARROW);
      drain();
    end
    s_tvalid <= 1'b0;

    // let any stray output show up
    repeat (3 * MAX_ELEM) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("subrange_integer_sorter: match");
    end else begin
      $display("subrange_integer_sorter: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ssi_pkg.sv
rtl/ssi_cell.sv
rtl/subrange_integer_sorter.sv
rtl/ssi_checker.sv
sim/tb_subrange_integer_sorter.sv
